// ----- sv/lbs_pkg.sv -----
package lbs_pkg;

    localparam int DataW = 32;
    localparam int ProdW = 2 * DataW;
    // Three products shifted down by 16 plus a translation need 50 bits.
    localparam int SumW  = 50;

    typedef struct packed {
        logic mul;
        logic init;
        logic add;
    } t_mac_ctl;

endpackage

// ----- sv/linear_blend_vertex_skinning.sv -----
// Linear blend skinning engine, Q16.16 positions and normals, Q1.16 weights.
// Input channel (i_in_valid / o_in_ready) takes one item at a time; o_in_ready
// is high only while the engine is idle. Loads, matrix rows, clears, restores
// and ignored items occupy the engine through the accept, vertex memory read
// and dispatch states. A read item places its result in the output
// register in the dispatch state. A weight item runs the shared 32x32
// multiplier and 50-bit adder through 7 steps per row, 3 rows and one
// write-back per vector, for positions and, with normals enabled, for normals.
// Output channel (o_out_valid / i_out_ready) is a single output register; a
// read item that finds it still full waits in dispatch until the receiver
// takes the earlier result, so a stalled receiver holds off the next read.
// Configuration channel (i_cfg_valid / o_cfg_ready) is always ready and
// writes normals_enabled; it is meant to be written while the engine is idle.
// Reset (synchronous, active low) empties the output register, loads the
// identity bone matrix and enables normals. Vertex memories are not cleared.
module linear_blend_vertex_skinning #(
    parameter int VERTICES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_kind,
    input  logic [9:0]         i_vertex_index,
    input  logic [1:0]         i_row_index,
    input  logic signed [31:0] i_a0,
    input  logic signed [31:0] i_a1,
    input  logic signed [31:0] i_a2,
    input  logic signed [31:0] i_a3,
    input  logic [16:0]        i_weight,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [9:0]         o_out_vertex,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [31:0] o_nrm_x,
    output logic signed [31:0] o_nrm_y,
    output logic signed [31:0] o_nrm_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_normals_enabled
);

    localparam int AW   = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int DW   = lbs_pkg::DataW;
    localparam int VecW = 3 * DW;
    localparam logic [16:0] VtxLimit  = 17'(VERTICES);
    localparam logic [16:0] WeightOne = 17'd65536;
    localparam logic signed [31:0] FixOne = 32'sh0001_0000;

    typedef enum logic [2:0] {
        KIND_LOAD_POS = 3'd0,
        KIND_LOAD_NRM = 3'd1,
        KIND_MATRIX   = 3'd2,
        KIND_WEIGHT   = 3'd3,
        KIND_CLEAR    = 3'd4,
        KIND_READ     = 3'd5,
        KIND_RESTORE  = 3'd6
    } t_kind;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_DISP = 5'b00100,
        ST_MAC  = 5'b01000,
        ST_WB   = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        STEP_INIT = 3'd0,
        STEP_MUL0 = 3'd1,
        STEP_MUL1 = 3'd2,
        STEP_MUL2 = 3'd3,
        STEP_ADD  = 3'd4,
        STEP_WMUL = 3'd5,
        STEP_ACC  = 3'd6
    } t_step;

    t_state r_state, n_state;
    t_step  r_step, n_step;
    logic [1:0] r_row, n_row;
    logic       r_pass, n_pass;
    logic       r_out_valid, n_out_valid;
    logic       r_nrm_en;
    logic signed [DW-1:0] r_mat [12];

    t_kind              r_kind;
    logic [AW-1:0]      r_addr;
    logic               r_vld;
    logic [1:0]         r_row_in;
    logic [9:0]         r_vtx;
    logic signed [DW-1:0] r_a [4];
    logic [16:0]        r_w;
    logic signed [DW-1:0] r_vec [3];
    logic signed [DW-1:0] r_acc [3];
    logic [9:0]         r_out_vertex;
    logic signed [DW-1:0] r_out_pos [3];
    logic signed [DW-1:0] r_out_nrm [3];

    logic in_acc, out_free, disp, wb;
    logic [VecW-1:0] bpos_rd, bnrm_rd, spos_rd, snrm_rd;
    logic            bpos_we, bnrm_we, spos_we, snrm_we;
    logic [VecW-1:0] load_vec, acc_vec, spos_wd, snrm_wd;
    logic [1:0]      mat_col;
    logic signed [DW-1:0] mat_rd, vec_rd, mul_a, mul_b, init_val, sum_sat, acc_next;
    lbs_pkg::t_mac_ctl mac_ctl;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;
    assign disp        = (r_state == ST_DISP);
    assign wb          = (r_state == ST_WB);
    assign o_cfg_ready = 1'b1;

    // Vertex memories: x in the low word, z in the high word.
    lbs_ram #(.DEPTH(VERTICES), .AW(AW), .DW(VecW)) u_bind_pos (
        .i_clk(i_clk), .i_we(bpos_we), .i_waddr(r_addr), .i_wdata(load_vec),
        .i_raddr(r_addr), .o_rdata(bpos_rd)
    );
    lbs_ram #(.DEPTH(VERTICES), .AW(AW), .DW(VecW)) u_bind_nrm (
        .i_clk(i_clk), .i_we(bnrm_we), .i_waddr(r_addr), .i_wdata(load_vec),
        .i_raddr(r_addr), .o_rdata(bnrm_rd)
    );
    lbs_ram #(.DEPTH(VERTICES), .AW(AW), .DW(VecW)) u_skin_pos (
        .i_clk(i_clk), .i_we(spos_we), .i_waddr(r_addr), .i_wdata(spos_wd),
        .i_raddr(r_addr), .o_rdata(spos_rd)
    );
    lbs_ram #(.DEPTH(VERTICES), .AW(AW), .DW(VecW)) u_skin_nrm (
        .i_clk(i_clk), .i_we(snrm_we), .i_waddr(r_addr), .i_wdata(snrm_wd),
        .i_raddr(r_addr), .o_rdata(snrm_rd)
    );

    assign load_vec = {r_a[2], r_a[1], r_a[0]};
    assign acc_vec  = {r_acc[2], r_acc[1], r_acc[0]};
    assign bpos_we  = disp && r_vld && (r_kind == KIND_LOAD_POS);
    assign bnrm_we  = disp && r_vld && (r_kind == KIND_LOAD_NRM);

    always_comb begin
        spos_we = 1'b0;
        spos_wd = acc_vec;
        snrm_we = 1'b0;
        snrm_wd = acc_vec;
        if (disp && r_vld && (r_kind == KIND_CLEAR)) begin
            spos_we = 1'b1;
            spos_wd = '0;
            snrm_we = r_nrm_en;
            snrm_wd = '0;
        end else if (disp && r_vld && (r_kind == KIND_RESTORE)) begin
            spos_we = 1'b1;
            spos_wd = bpos_rd;
            snrm_we = r_nrm_en;
            snrm_wd = bnrm_rd;
        end else if (wb) begin
            spos_we = !r_pass;
            snrm_we = r_pass;
        end
    end

    // Operand selection for the shared multiplier and adder.
    always_comb begin
        case (r_step)
            STEP_INIT: mat_col = 2'd3;
            STEP_MUL0: mat_col = 2'd0;
            STEP_MUL1: mat_col = 2'd1;
            default:   mat_col = 2'd2;
        endcase
    end

    assign mat_rd = r_mat[{r_row, mat_col}];

    always_comb begin
        case (r_step)
            STEP_MUL0: vec_rd = r_vec[0];
            STEP_MUL1: vec_rd = r_vec[1];
            default:   vec_rd = r_vec[2];
        endcase
    end

    assign mul_a    = (r_step == STEP_WMUL) ? sum_sat : mat_rd;
    assign mul_b    = (r_step == STEP_WMUL) ? $signed({15'd0, r_w}) : vec_rd;
    // Normals take no translation.
    assign init_val = r_pass ? '0 : mat_rd;

    always_comb begin
        mac_ctl.mul  = (r_state == ST_MAC) &&
                       ((r_step == STEP_MUL0) || (r_step == STEP_MUL1) ||
                        (r_step == STEP_MUL2) || (r_step == STEP_WMUL));
        mac_ctl.init = (r_state == ST_MAC) && (r_step == STEP_INIT);
        mac_ctl.add  = (r_state == ST_MAC) &&
                       ((r_step == STEP_MUL1) || (r_step == STEP_MUL2) ||
                        (r_step == STEP_ADD));
    end

    lbs_mac u_mac (
        .i_clk      (i_clk),
        .i_ctl      (mac_ctl),
        .i_mul_a    (mul_a),
        .i_mul_b    (mul_b),
        .i_init     (init_val),
        .i_acc      (r_acc[r_row]),
        .o_sum_sat  (sum_sat),
        .o_acc_next (acc_next)
    );

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_row       = r_row;
        n_pass      = r_pass;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_DISP;
            end
            ST_DISP: begin
                case (r_kind)
                    KIND_WEIGHT: begin
                        if (r_vld) begin
                            n_state = ST_MAC;
                            n_step  = STEP_INIT;
                            n_row   = 2'd0;
                            n_pass  = 1'b0;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                    KIND_READ: begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_state     = ST_IDLE;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_MAC: begin
                if (r_step == STEP_ACC) begin
                    n_step = STEP_INIT;
                    if (r_row == 2'd2) begin
                        n_state = ST_WB;
                    end else begin
                        n_row = r_row + 2'd1;
                    end
                end else begin
                    n_step = t_step'(r_step + 3'd1);
                end
            end
            ST_WB: begin
                if (!r_pass && r_nrm_en) begin
                    n_state = ST_MAC;
                    n_pass  = 1'b1;
                    n_row   = 2'd0;
                    n_step  = STEP_INIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_INIT;
            r_row       <= 2'd0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
            r_nrm_en    <= 1'b1;
            for (int i = 0; i < 12; i++) begin
                r_mat[i] <= ((i == 0) || (i == 5) || (i == 10)) ? FixOne : '0;
            end
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_row       <= n_row;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_nrm_en <= i_normals_enabled;
            end
            if (disp && (r_kind == KIND_MATRIX) && (r_row_in != 2'd3)) begin
                for (int c = 0; c < 4; c++) begin
                    r_mat[{r_row_in, 2'(c)}] <= r_a[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind   <= t_kind'(i_kind);
            r_vtx    <= i_vertex_index;
            r_addr   <= AW'(i_vertex_index);
            r_vld    <= (17'(i_vertex_index) < VtxLimit);
            r_row_in <= i_row_index;
            r_a[0]   <= i_a0;
            r_a[1]   <= i_a1;
            r_a[2]   <= i_a2;
            r_a[3]   <= i_a3;
            r_w      <= (i_weight > WeightOne) ? WeightOne : i_weight;
        end
        if (disp && (r_kind == KIND_WEIGHT)) begin
            for (int i = 0; i < 3; i++) begin
                r_vec[i] <= bpos_rd[i*DW +: DW];
                r_acc[i] <= spos_rd[i*DW +: DW];
            end
        end else if (wb && !r_pass) begin
            for (int i = 0; i < 3; i++) begin
                r_vec[i] <= bnrm_rd[i*DW +: DW];
                r_acc[i] <= snrm_rd[i*DW +: DW];
            end
        end else if ((r_state == ST_MAC) && (r_step == STEP_ACC)) begin
            r_acc[r_row] <= acc_next;
        end
        if (disp && (r_kind == KIND_READ) && out_free) begin
            r_out_vertex <= r_vtx;
            for (int i = 0; i < 3; i++) begin
                r_out_pos[i] <= r_vld ? $signed(spos_rd[i*DW +: DW]) : '0;
                r_out_nrm[i] <= (r_vld && r_nrm_en) ? $signed(snrm_rd[i*DW +: DW]) : '0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_vertex = r_out_vertex;
    assign o_pos_x      = r_out_pos[0];
    assign o_pos_y      = r_out_pos[1];
    assign o_pos_z      = r_out_pos[2];
    assign o_nrm_x      = r_out_nrm[0];
    assign o_nrm_y      = r_out_nrm[1];
    assign o_nrm_z      = r_out_nrm[2];

endmodule

// ----- sv/lbs_ram.sv -----
module lbs_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 96
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/lbs_mac.sv -----
module lbs_mac (
    input  logic                                i_clk,
    input  lbs_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [lbs_pkg::DataW-1:0]    i_mul_a,
    input  logic signed [lbs_pkg::DataW-1:0]    i_mul_b,
    input  logic signed [lbs_pkg::DataW-1:0]    i_init,
    input  logic signed [lbs_pkg::DataW-1:0]    i_acc,
    output logic signed [lbs_pkg::DataW-1:0]    o_sum_sat,
    output logic signed [lbs_pkg::DataW-1:0]    o_acc_next
);

    logic signed [lbs_pkg::ProdW-1:0] r_prod;
    logic signed [lbs_pkg::SumW-1:0]  r_sum;
    logic signed [lbs_pkg::SumW-1:0]  prod_shr;
    logic signed [lbs_pkg::SumW-1:0]  acc_sum;

    function automatic logic signed [lbs_pkg::DataW-1:0] sat32(
        input logic signed [lbs_pkg::SumW-1:0] v
    );
        logic [lbs_pkg::SumW-lbs_pkg::DataW:0] top_bits;
        top_bits = v[lbs_pkg::SumW-1:lbs_pkg::DataW-1];
        if ((top_bits == '0) || (top_bits == '1)) begin
            return v[lbs_pkg::DataW-1:0];
        end else if (v[lbs_pkg::SumW-1]) begin
            return {1'b1, {(lbs_pkg::DataW-1){1'b0}}};
        end else begin
            return {1'b0, {(lbs_pkg::DataW-1){1'b1}}};
        end
    endfunction

    // Dropping the low 16 bits of a signed product rounds toward minus infinity.
    assign prod_shr   = lbs_pkg::SumW'($signed(r_prod[lbs_pkg::ProdW-1:16]));
    assign acc_sum    = lbs_pkg::SumW'(i_acc) + prod_shr;
    assign o_sum_sat  = sat32(r_sum);
    assign o_acc_next = sat32(acc_sum);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= i_mul_a * i_mul_b;
        end
        if (i_ctl.init) begin
            r_sum <= lbs_pkg::SumW'(i_init);
        end else if (i_ctl.add) begin
            r_sum <= r_sum + prod_shr;
        end
    end

endmodule

// ----- verif/tb.sv -----
module tb;

    localparam int NUM_VERTS    = 1024;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [16:0] W_ONE = 17'd65536;
    localparam logic [1:0]  ROW_NONE = 2'd3;
    localparam longint      SAT_HI = 64'sd2147483647;
    localparam longint      SAT_LO = -64'sd2147483648;

    typedef enum logic [2:0] {
        OP_LOAD_POS = 3'd0,
        OP_LOAD_NRM = 3'd1,
        OP_ROW      = 3'd2,
        OP_WEIGHT   = 3'd3,
        OP_CLEAR    = 3'd4,
        OP_READ     = 3'd5,
        OP_RESTORE  = 3'd6,
        OP_SKIP     = 3'd7
    } skin_op_e;

    typedef struct packed {
        skin_op_e    kind;
        logic [9:0]  vtx;
        logic [1:0]  row;
        logic [31:0] a0;
        logic [31:0] a1;
        logic [31:0] a2;
        logic [31:0] a3;
        logic [16:0] weight;
        logic [2:0]  gap;
    } skin_item_t;

    typedef struct packed {
        logic [9:0]  vtx;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
    } vertex_read_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic i_normals_enabled = 1'b1;
    skin_item_t tx_cur = '0;

    wire [2:0]         i_kind = tx_cur.kind;
    wire [9:0]         i_vertex_index = tx_cur.vtx;
    wire [1:0]         i_row_index = tx_cur.row;
    wire signed [31:0] i_a0 = tx_cur.a0;
    wire signed [31:0] i_a1 = tx_cur.a1;
    wire signed [31:0] i_a2 = tx_cur.a2;
    wire signed [31:0] i_a3 = tx_cur.a3;
    wire [16:0]        i_weight = tx_cur.weight;

    logic               o_in_ready;
    logic               o_out_valid;
    logic [9:0]         o_out_vertex;
    logic signed [31:0] o_pos_x;
    logic signed [31:0] o_pos_y;
    logic signed [31:0] o_pos_z;
    logic signed [31:0] o_nrm_x;
    logic signed [31:0] o_nrm_y;
    logic signed [31:0] o_nrm_z;
    logic               o_cfg_ready;

    linear_blend_vertex_skinning #(
        .VERTICES(NUM_VERTS)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_vertex_index   (i_vertex_index),
        .i_row_index      (i_row_index),
        .i_a0             (i_a0),
        .i_a1             (i_a1),
        .i_a2             (i_a2),
        .i_a3             (i_a3),
        .i_weight         (i_weight),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_vertex     (o_out_vertex),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_pos_z          (o_pos_z),
        .o_nrm_x          (o_nrm_x),
        .o_nrm_y          (o_nrm_y),
        .o_nrm_z          (o_nrm_z),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_normals_enabled(i_normals_enabled)
    );

    // Predicted engine state.
    int bind_pos [3*NUM_VERTS];
    int bind_nrm [3*NUM_VERTS];
    int skin_pos [3*NUM_VERTS];
    int skin_nrm [3*NUM_VERTS];
    int bone [12] = '{65536, 0, 0, 0, 0, 65536, 0, 0, 0, 0, 65536, 0};
    bit nrm_en = 1'b1;

    skin_item_t   items_to_send [$];
    vertex_read_t reads_due [$];
    int           mismatches = 0;

    // Which stores the generator has already written, so no item reads an
    // entry that was never written.
    bit bp_set [NUM_VERTS];
    bit bn_set [NUM_VERTS];
    bit sp_set [NUM_VERTS];
    bit sn_set [NUM_VERTS];
    bit gen_nrm = 1'b1;
    bit gen_burst = 1'b0;
    int gen_count = 0;
    int vtx_pool [$];

    int  phase_no = 0;
    bit  long_hold = 1'b0;
    bit  in_took = 1'b0;
    bit  out_took = 1'b0;
    int  tx_idle = 0;
    int  rx_wait = 0;
    int  rx_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int clamp32(longint v);
        if (v > SAT_HI) return int'(SAT_HI);
        if (v < SAT_LO) return int'(SAT_LO);
        return int'(v);
    endfunction

    // One row of the bone matrix times a vector; each product is floored
    // before the exact sum.
    function automatic int bone_row_dot(int r, int x, int y, int z, bit with_shift);
        longint s;
        s = ((longint'(bone[r*4])   * longint'(x)) >>> 16)
          + ((longint'(bone[r*4+1]) * longint'(y)) >>> 16)
          + ((longint'(bone[r*4+2]) * longint'(z)) >>> 16);
        if (with_shift) s = s + longint'(bone[r*4+3]);
        return clamp32(s);
    endfunction

    function automatic void blend_into(bit of_normal, int base, longint w);
        int     src [3];
        int     t;
        longint add;
        int     r;
        for (r = 0; r < 3; r++)
            src[r] = of_normal ? bind_nrm[base+r] : bind_pos[base+r];
        for (r = 0; r < 3; r++) begin
            t = bone_row_dot(r, src[0], src[1], src[2], !of_normal);
            add = (longint'(t) * w) >>> 16;
            if (of_normal)
                skin_nrm[base+r] = clamp32(longint'(skin_nrm[base+r]) + add);
            else
                skin_pos[base+r] = clamp32(longint'(skin_pos[base+r]) + add);
        end
    endfunction

    function automatic void skin_apply(skin_item_t it);
        int           base;
        longint       w;
        vertex_read_t res;
        int           i;
        base = int'(it.vtx) * 3;
        w = (it.weight > W_ONE) ? 65536 : longint'(it.weight);
        case (it.kind)
            OP_LOAD_POS: begin
                bind_pos[base] = it.a0;
                bind_pos[base+1] = it.a1;
                bind_pos[base+2] = it.a2;
            end
            OP_LOAD_NRM: begin
                bind_nrm[base] = it.a0;
                bind_nrm[base+1] = it.a1;
                bind_nrm[base+2] = it.a2;
            end
            OP_ROW: begin
                if (it.row != ROW_NONE) begin
                    bone[it.row*4]   = it.a0;
                    bone[it.row*4+1] = it.a1;
                    bone[it.row*4+2] = it.a2;
                    bone[it.row*4+3] = it.a3;
                end
            end
            OP_WEIGHT: begin
                blend_into(1'b0, base, w);
                if (nrm_en) blend_into(1'b1, base, w);
            end
            OP_CLEAR: begin
                for (i = 0; i < 3; i++) begin
                    skin_pos[base+i] = 0;
                    if (nrm_en) skin_nrm[base+i] = 0;
                end
            end
            OP_RESTORE: begin
                for (i = 0; i < 3; i++) begin
                    skin_pos[base+i] = bind_pos[base+i];
                    if (nrm_en) skin_nrm[base+i] = bind_nrm[base+i];
                end
            end
            OP_READ: begin
                res.vtx = it.vtx;
                res.px = skin_pos[base];
                res.py = skin_pos[base+1];
                res.pz = skin_pos[base+2];
                res.nx = nrm_en ? skin_nrm[base] : 0;
                res.ny = nrm_en ? skin_nrm[base+1] : 0;
                res.nz = nrm_en ? skin_nrm[base+2] : 0;
                reads_due.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endfunction

    // Input and configuration acceptance feed the predictor.
    always @(posedge i_clk) begin
        in_took <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) nrm_en = i_normals_enabled;
        if (i_rst_n && i_in_valid && o_in_ready) skin_apply(tx_cur);
    end

    // Result checker.
    always @(posedge i_clk) begin
        vertex_read_t want;
        out_took <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reads_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result for vertex %0d with no read pending", o_out_vertex);
            end else begin
                want = reads_due.pop_front();
                check_field("out_vertex", {22'd0, want.vtx}, {22'd0, o_out_vertex});
                check_field("pos_x", want.px, o_pos_x);
                check_field("pos_y", want.py, o_pos_y);
                check_field("pos_z", want.pz, o_pos_z);
                check_field("nrm_x", want.nx, o_nrm_x);
                check_field("nrm_y", want.ny, o_nrm_y);
                check_field("nrm_z", want.nz, o_nrm_z);
            end
        end
    end

    // Sender: each item waits its own gap before it is offered.
    always @(negedge i_clk) begin
        skin_item_t nxt;
        if (i_rst_n && (!i_in_valid || in_took)) begin
            if (items_to_send.size() != 0 && tx_idle >= int'(items_to_send[0].gap)) begin
                nxt = items_to_send.pop_front();
                tx_cur <= nxt;
                i_in_valid <= 1'b1;
                tx_idle = 0;
            end else begin
                i_in_valid <= 1'b0;
                tx_idle++;
            end
        end
    end

    // Receiver: a random stall after each item, none for some stretches.
    always @(negedge i_clk) begin
        if (out_took) begin
            rx_count++;
            rx_wait = (rx_count % 32 < 8) ? 0 : $urandom_range(0, 7);
        end
        if (rx_wait > 0) begin
            rx_wait--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !long_hold;
        end
    end

    // A long receiver stall partway into one phase, so that the output register
    // stays full and the engine stops taking items.
    initial begin
        wait (phase_no == 2);
        repeat (30) @(posedge i_clk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold = 1'b0;
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2, 3: return $urandom();
            default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 11))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return $urandom();
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return W_ONE;
            2: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic skin_item_t make_item(skin_op_e k, int v, logic [1:0] row,
                                             logic [31:0] x0, logic [31:0] x1,
                                             logic [31:0] x2, logic [31:0] x3,
                                             logic [16:0] w);
        skin_item_t it;
        it.kind = k;
        it.vtx = 10'(v);
        it.row = row;
        it.a0 = x0;
        it.a1 = x1;
        it.a2 = x2;
        it.a3 = x3;
        it.weight = w;
        it.gap = gen_burst ? 3'd0 : 3'($urandom_range(0, 7));
        return it;
    endfunction

    function automatic bit item_ok(skin_item_t it);
        int v;
        v = int'(it.vtx);
        case (it.kind)
            OP_WEIGHT:  return bp_set[v] && sp_set[v] && (!gen_nrm || (bn_set[v] && sn_set[v]));
            OP_READ:    return sp_set[v] && (!gen_nrm || sn_set[v]);
            OP_RESTORE: return bp_set[v] && (!gen_nrm || bn_set[v]);
            default:    return 1'b1;
        endcase
    endfunction

    // Queues an item; one that would read an unwritten entry becomes a load.
    function automatic void send(skin_item_t it);
        int v;
        v = int'(it.vtx);
        if (!item_ok(it)) it.kind = OP_LOAD_POS;
        case (it.kind)
            OP_LOAD_POS: bp_set[v] = 1'b1;
            OP_LOAD_NRM: bn_set[v] = 1'b1;
            OP_CLEAR, OP_RESTORE: begin
                sp_set[v] = 1'b1;
                if (gen_nrm) sn_set[v] = 1'b1;
            end
            default: ;
        endcase
        items_to_send.push_back(it);
        gen_count++;
    endfunction

    function automatic void send_simple(skin_op_e k, int v, logic [16:0] w);
        send(make_item(k, v, 2'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), w));
    endfunction

    function automatic bit vtx_ready(int v);
        return bp_set[v] && sp_set[v] && (!gen_nrm || (bn_set[v] && sn_set[v]));
    endfunction

    function automatic int pick_vertex();
        if (vtx_pool.size() != 0 && $urandom_range(0, 1) == 1)
            return vtx_pool[$urandom_range(0, vtx_pool.size() - 1)];
        return $urandom_range(0, NUM_VERTS - 1);
    endfunction

    // Mostly load/skin/read sequences on one vertex, with stray items between.
    task automatic random_phase(int n_items);
        int start;
        int v;
        int n;
        int j;
        start = gen_count;
        while (gen_count - start < n_items) begin
            gen_burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0) begin
                send(make_item(skin_op_e'($urandom_range(0, 7)), pick_vertex(),
                               2'($urandom_range(0, 3)), $urandom(), $urandom(),
                               $urandom(), $urandom(), 17'($urandom_range(0, 131071))));
            end else begin
                v = pick_vertex();
                if (!vtx_ready(v) || $urandom_range(0, 7) == 0) begin
                    send_simple(OP_LOAD_POS, v, rand_weight());
                    send_simple(OP_LOAD_NRM, v, rand_weight());
                    send_simple(($urandom_range(0, 1) == 1) ? OP_CLEAR : OP_RESTORE, v,
                                rand_weight());
                end
                n = $urandom_range(0, 3);
                for (j = 0; j < n; j++)
                    send(make_item(OP_ROW, pick_vertex(), 2'($urandom_range(0, 2)),
                                   rand_elem(), rand_elem(), rand_elem(), rand_coord(),
                                   rand_weight()));
                n = $urandom_range(1, 4);
                for (j = 0; j < n; j++) begin
                    send_simple(OP_WEIGHT, v, rand_weight());
                    if ($urandom_range(0, 9) == 0)
                        send_simple(($urandom_range(0, 1) == 1) ? OP_CLEAR : OP_RESTORE, v,
                                    rand_weight());
                end
                send_simple(OP_READ, v, rand_weight());
                vtx_pool.push_back(v);
            end
        end
    endtask

    task automatic write_normals(bit en);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_normals_enabled <= en;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every item is taken and every read answered, then lets a
    // weight item still in flight finish.
    task automatic settle();
        while (items_to_send.size() != 0 || i_in_valid || reads_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int p;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        gen_nrm = 1'b1;
        write_normals(1'b1);

        // Directed: field extremes, each kind, saturation, weight clamping,
        // the ignored row and the ignored kind.
        send(make_item(OP_LOAD_POS, 0, 2'd0, Q_MAX, Q_MIN, 32'd0, Q_MAX, 17'd0));
        send(make_item(OP_LOAD_NRM, 0, 2'd1, Q_MIN, Q_MAX, Q_ONE, Q_MIN, W_ONE));
        send(make_item(OP_RESTORE, 0, 2'd2, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 17'd1));
        send(make_item(OP_READ, 0, 2'd3, 32'd0, 32'd0, 32'd0, 32'd0, 17'd0));
        send(make_item(OP_ROW, 0, ROW_NONE, Q_MAX, Q_MAX, Q_MAX, Q_MAX, W_ONE));
        send(make_item(OP_SKIP, 0, 2'd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 17'h1ffff));
        send(make_item(OP_WEIGHT, 0, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, W_ONE));
        send(make_item(OP_READ, 0, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 17'd0));
        send(make_item(OP_ROW, 1023, 2'd0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 17'd0));
        send(make_item(OP_ROW, 1023, 2'd1, Q_MIN, Q_MIN, Q_MIN, Q_MAX, 17'd0));
        send(make_item(OP_ROW, 1023, 2'd2, 32'h0002_0000, 32'hfffe_0000, 32'h0000_8000,
                       Q_ONE, 17'd0));
        send(make_item(OP_LOAD_POS, 1023, 2'd3, Q_MAX, Q_MAX, Q_MAX, 32'd0, 17'h1ffff));
        send(make_item(OP_LOAD_NRM, 1023, 2'd3, Q_MIN, Q_MIN, Q_MIN, 32'd0, 17'h1ffff));
        send(make_item(OP_CLEAR, 1023, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 17'd0));
        send(make_item(OP_WEIGHT, 1023, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 17'h1ffff));
        send(make_item(OP_WEIGHT, 1023, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 17'd0));
        send(make_item(OP_READ, 1023, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 17'd0));
        send(make_item(OP_WEIGHT, 0, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 17'd1));
        send(make_item(OP_READ, 0, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 17'd0));
        send(make_item(OP_CLEAR, 0, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 17'd0));
        send(make_item(OP_READ, 0, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 17'd0));
        send(make_item(OP_RESTORE, 1023, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 17'd0));
        send(make_item(OP_READ, 1023, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 17'd0));
        vtx_pool.push_back(0);
        vtx_pool.push_back(1023);
        settle();

        // Random phases alternate normals off and on.
        for (p = 1; p <= 4; p++) begin
            gen_nrm = (p % 2 == 0);
            write_normals(gen_nrm);
            phase_no = p;
            random_phase(100);
            settle();
        end

        if (mismatches == 0 && reads_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/lbs_pkg.sv
sv/lbs_ram.sv
sv/lbs_mac.sv
sv/linear_blend_vertex_skinning.sv
verif/tb.sv
